/* hdl/srle_pkg.sv */
`default_nettype none
package srle_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_PIXEL_BITS = 8;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic [1:0] CFG_ORIGIN_COL    = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_ROW    = 2'd1;
    localparam logic [1:0] CFG_REGION_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_REGION_HEIGHT = 2'd3;

    localparam logic [12:0] RST_REGION_WIDTH  = 13'd640;
    localparam logic [12:0] RST_REGION_HEIGHT = 13'd480;

    typedef struct packed {
        logic [12:0] run_start;
        logic [13:0] run_end;
        logic [12:0] run_row;
        logic [7:0]  run_value;
        logic        row_final;
        logic        last;
    } t_run;

    typedef struct packed {
        logic [1:0] cnt;
        t_run       e0;
        t_run       e1;
    } t_fifo_wr;

endpackage
`default_nettype wire

/* hdl/srle_pix_if.sv */
`default_nettype none
interface srle_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface
`default_nettype wire

/* hdl/srle_run_if.sv */
`default_nettype none
interface srle_run_if;
    logic        valid;
    logic        ready;
    logic [12:0] run_start;
    logic [13:0] run_end;
    logic [12:0] run_row;
    logic [7:0]  run_value;
    logic        row_final;
    logic        last;

    modport source (output valid, output run_start, output run_end, output run_row,
                    output run_value, output row_final, output last, input ready);
    modport sink (input valid, input run_start, input run_end, input run_row,
                  input run_value, input row_final, input last, output ready);
endinterface
`default_nettype wire

/* hdl/scanline_run_length_encoder_core.sv */
// a result passes through the input register and the result queue before it is offered
// throughput: one pixel per cycle while the result queue has room, set by the single-pass run update stage
// a row ending in a differing pixel gives two results, drained by the four-entry
// result queue one per cycle while ready is high; pixels stall while fewer than two slots are free
// reset (synchronous, active low): counters cleared, queue emptied, registers to defaults
`default_nettype none
module scanline_run_length_encoder_core #(
    parameter int MAX_WIDTH  = srle_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = srle_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = srle_pkg::DEF_PIXEL_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data,
    srle_pix_if.sink         i_pix,
    srle_run_if.source       o_run
);
    import srle_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PIX_W = (PIXEL_BITS < 8) ? PIXEL_BITS : 8;
    localparam logic [7:0] PX_MASK = 8'((9'd1 << PIX_W) - 9'd1);
    localparam logic [13:0] MAX_W14 = 14'(MAX_WIDTH);
    localparam logic [13:0] MAX_H14 = 14'(MAX_HEIGHT);

    logic [11:0]      r_origin_col;
    logic [11:0]      r_origin_row;
    logic [12:0]      r_region_width;
    logic [12:0]      r_region_height;

    logic             r_in_valid;
    logic [7:0]       r_in_pixel;

    logic [7:0]       r_cur_value;
    logic [COL_W-1:0] r_cur_start;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic [7:0]       n_cur_value;
    logic [COL_W-1:0] n_cur_start;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    logic [13:0]      width_eff;
    logic [13:0]      height_eff;
    logic [7:0]       px;
    logic [13:0]      col_inc;
    logic [13:0]      row_inc;
    logic             run_break;
    logic             row_end;
    logic [COL_W-1:0] start_new;
    logic             fifo_room;
    logic             proc;
    t_run             run_a;
    t_run             run_b;
    t_fifo_wr         fifo_wr;
    t_run             fifo_out;
    logic             fifo_valid;

    function automatic logic [13:0] clamp_dim(logic [12:0] v, logic [13:0] maxv);
        logic [13:0] r;
        r = {1'b0, v};
        if (v == 13'd0) begin
            r = 14'd1;
        end else if ({1'b0, v} > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_col    <= '0;
            r_origin_row    <= '0;
            r_region_width  <= RST_REGION_WIDTH;
            r_region_height <= RST_REGION_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ORIGIN_COL:    r_origin_col    <= i_cfg_data[11:0];
                CFG_ORIGIN_ROW:    r_origin_row    <= i_cfg_data[11:0];
                CFG_REGION_WIDTH:  r_region_width  <= i_cfg_data;
                CFG_REGION_HEIGHT: r_region_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign proc        = r_in_valid && fifo_room;
    assign i_pix.ready = !r_in_valid || fifo_room;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_in_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.ready && i_pix.valid) begin
            r_in_pixel <= i_pix.pixel;
        end
    end

    // run update
    always_comb begin
        width_eff  = clamp_dim(r_region_width, MAX_W14);
        height_eff = clamp_dim(r_region_height, MAX_H14);
        px         = r_in_pixel & PX_MASK;
        col_inc    = 14'(r_col) + 14'd1;
        row_inc    = 14'(r_row) + 14'd1;
        run_break  = (r_col != '0) && (px != r_cur_value);
        row_end    = (col_inc >= width_eff);

        if (r_col == '0) begin
            start_new = '0;
        end else if (run_break) begin
            start_new = r_col;
        end else begin
            start_new = r_cur_start;
        end

        run_a.run_start = 13'(r_origin_col) + 13'(r_cur_start);
        run_a.run_end   = 14'(r_origin_col) + 14'(r_col);
        run_a.run_row   = 13'(r_origin_row) + 13'(r_row);
        run_a.run_value = r_cur_value;
        run_a.row_final = 1'b0;
        run_a.last      = !row_end;

        run_b.run_start = 13'(r_origin_col) + 13'(start_new);
        run_b.run_end   = 14'(r_origin_col) + col_inc;
        run_b.run_row   = 13'(r_origin_row) + 13'(r_row);
        run_b.run_value = px;
        run_b.row_final = 1'b1;
        run_b.last      = 1'b1;

        fifo_wr.cnt = 2'd0;
        fifo_wr.e0  = run_a;
        fifo_wr.e1  = run_b;
        if (proc) begin
            if (run_break && row_end) begin
                fifo_wr.cnt = 2'd2;
            end else if (run_break) begin
                fifo_wr.cnt = 2'd1;
            end else if (row_end) begin
                fifo_wr.cnt = 2'd1;
                fifo_wr.e0  = run_b;
            end
        end

        n_cur_value = px;
        if (row_end) begin
            n_cur_start = '0;
            n_col       = '0;
            n_row       = (row_inc >= height_eff) ? '0 : ROW_W'(row_inc);
        end else begin
            n_cur_start = start_new;
            n_col       = COL_W'(col_inc);
            n_row       = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_value <= '0;
            r_cur_start <= '0;
            r_col       <= '0;
            r_row       <= '0;
        end else if (proc) begin
            r_cur_value <= n_cur_value;
            r_cur_start <= n_cur_start;
            r_col       <= n_col;
            r_row       <= n_row;
        end
    end

    srle_run_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fifo_wr),
        .o_room  (fifo_room),
        .o_valid (fifo_valid),
        .o_data  (fifo_out),
        .i_ready (o_run.ready)
    );

    assign o_run.valid     = fifo_valid;
    assign o_run.run_start = fifo_out.run_start;
    assign o_run.run_end   = fifo_out.run_end;
    assign o_run.run_row   = fifo_out.run_row;
    assign o_run.run_value = fifo_out.run_value;
    assign o_run.row_final = fifo_out.row_final;
    assign o_run.last      = fifo_out.last;
endmodule
`default_nettype wire

/* hdl/srle_run_fifo.sv */
`default_nettype none
module srle_run_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire srle_pkg::t_fifo_wr i_wr,
    output logic                    o_room,
    output logic                    o_valid,
    output srle_pkg::t_run          o_data,
    input  wire logic               i_ready
);
    import srle_pkg::*;

    t_run                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr;
    logic [FIFO_PTR_W-1:0] r_rd;
    logic [FIFO_CNT_W-1:0] r_cnt;
    logic [FIFO_PTR_W-1:0] n_wr;
    logic [FIFO_PTR_W-1:0] n_rd;
    logic [FIFO_CNT_W-1:0] n_cnt;
    logic                  pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign o_room  = (r_cnt <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr  = r_wr + FIFO_PTR_W'(i_wr.cnt);
        n_rd  = r_rd + FIFO_PTR_W'(pop);
        n_cnt = r_cnt + FIFO_CNT_W'(i_wr.cnt) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.cnt != 2'd0) begin
            r_mem[r_wr] <= i_wr.e0;
        end
        if (i_wr.cnt == 2'd2) begin
            r_mem[r_wr + FIFO_PTR_W'(1)] <= i_wr.e1;
        end
    end
endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
    import srle_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [12:0] i_cfg_data;

    srle_pix_if pix_ch();
    srle_run_if run_ch();

    scanline_run_length_encoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix_ch),
        .o_run       (run_ch)
    );

    always #10 i_clk = ~i_clk;

    int unsigned pix_gap_pct;
    int unsigned run_stall_pct;
    int          error_count;

    // encoder model state
    logic [11:0] org_col;
    logic [11:0] org_row;
    logic [12:0] reg_width;
    logic [12:0] reg_height;
    logic [7:0]  run_value_q;
    logic [12:0] run_start_q;
    logic [12:0] col_q;
    logic [11:0] row_q;

    t_run expected_runs[$];

    function automatic t_run run_result(int unsigned end_col, logic final_flag);
        t_run        r;
        int unsigned sum;
        sum = int'(org_col) + int'(run_start_q);
        r.run_start = sum[12:0];
        sum = int'(org_col) + end_col;
        r.run_end = sum[13:0];
        sum = int'(org_row) + int'(row_q);
        r.run_row = sum[12:0];
        r.run_value = run_value_q;
        r.row_final = final_flag;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic predict_runs(input logic [7:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int          n;
        w = (reg_width == 0) ? 1 : ((reg_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : reg_width);
        h = (reg_height == 0) ? 1 : ((reg_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : reg_height);
        c = col_q;
        n = 0;
        if (c == 0) begin
            run_value_q = px;
            run_start_q = '0;
        end else if (px != run_value_q) begin
            expected_runs.push_back(run_result(c, 1'b0));
            n++;
            run_start_q = c[12:0];
            run_value_q = px;
        end
        if (c + 1 >= w) begin
            expected_runs.push_back(run_result(c + 1, 1'b1));
            n++;
            col_q = '0;
            row_q = (int'(row_q) + 1 >= h) ? '0 : row_q + 1'b1;
            run_start_q = '0;
        end else begin
            col_q = c[12:0] + 1'b1;
        end
        if (n > 0)
            expected_runs[expected_runs.size() - 1].last = 1'b1;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ORIGIN_COL:    org_col = val[11:0];
            CFG_ORIGIN_ROW:    org_row = val[11:0];
            CFG_REGION_WIDTH:  reg_width = val;
            CFG_REGION_HEIGHT: reg_height = val;
            default: ;
        endcase
    endtask

    task automatic send_pixel(input logic [7:0] px);
        @(negedge i_clk);
        while ($urandom_range(99) < pix_gap_pct) begin
            pix_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= px;
        do @(posedge i_clk); while (!pix_ch.ready);
        predict_runs(px);
    endtask

    task automatic settle();
        @(negedge i_clk);
        pix_ch.valid <= 1'b0;
        while (expected_runs.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(negedge i_clk)
        run_ch.ready <= ($urandom_range(99) >= run_stall_pct);

    always @(posedge i_clk) begin
        t_run want;
        if (i_rst_n && run_ch.valid && run_ch.ready) begin
            if (expected_runs.size() == 0) begin
                $display("%0t: unexpected run, expected none, actual %0d..%0d row %0d value %0d",
                         $time, run_ch.run_start, run_ch.run_end, run_ch.run_row,
                         run_ch.run_value);
                error_count++;
            end else begin
                want = expected_runs.pop_front();
                compare_field("run_start", want.run_start, run_ch.run_start);
                compare_field("run_end", want.run_end, run_ch.run_end);
                compare_field("run_row", want.run_row, run_ch.run_row);
                compare_field("run_value", want.run_value, run_ch.run_value);
                compare_field("row_final", want.row_final, run_ch.row_final);
                compare_field("last", want.last, run_ch.last);
            end
        end
    end

    task automatic test_reset_values();
        send_pixel(8'd5);
        send_pixel(8'd5);
        send_pixel(8'd9);
        send_pixel(8'd9);
    endtask

    // width and height shrunk below the counters part way through a row
    task automatic test_config_mid_row();
        settle();
        write_reg(CFG_REGION_WIDTH, 13'd2);
        send_pixel(8'd9);
        settle();
        write_reg(CFG_REGION_HEIGHT, 13'd1);
        send_pixel(8'd3);
        send_pixel(8'd4);
    endtask

    // zero sizes count as one, origin bits above 12 dropped
    task automatic test_single_pixel_rows();
        settle();
        write_reg(CFG_ORIGIN_COL, 13'h1fff);
        write_reg(CFG_ORIGIN_ROW, 13'h1fff);
        write_reg(CFG_REGION_WIDTH, 13'd0);
        write_reg(CFG_REGION_HEIGHT, 13'd0);
        send_pixel(8'h00);
        send_pixel(8'hff);
        send_pixel(8'haa);
        send_pixel(8'h55);
    endtask

    task automatic test_differing_last();
        logic [7:0] seq[9];
        settle();
        write_reg(CFG_ORIGIN_COL, 13'd100);
        write_reg(CFG_ORIGIN_ROW, 13'd200);
        write_reg(CFG_REGION_WIDTH, 13'd3);
        write_reg(CFG_REGION_HEIGHT, 13'd2);
        seq = '{8'd1, 8'd1, 8'd2, 8'd7, 8'd8, 8'd9, 8'd4, 8'd4, 8'd4};
        foreach (seq[i])
            send_pixel(seq[i]);
    endtask

    task automatic test_random_frames(input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        int unsigned pick;
        logic [7:0]  px;
        logic [12:0] val;
        sent = 0;
        px = 8'd0;
        while (sent < n_items) begin
            settle();
            for (int idx = 0; idx < 4; idx++) begin
                if ($urandom_range(99) < 40) begin
                    pick = $urandom_range(99);
                    if (idx == CFG_ORIGIN_COL || idx == CFG_ORIGIN_ROW)
                        val = (pick < 15) ? 13'd0 : (pick < 30) ? 13'd4095 :
                              13'($urandom_range(8191));
                    else if (pick < 10)
                        val = 13'd0;
                    else if (pick < 15)
                        val = 13'($urandom_range(8191, 4097));
                    else if (pick < 18)
                        val = 13'd4096;
                    else if (idx == CFG_REGION_WIDTH)
                        val = 13'($urandom_range(24, 1));
                    else
                        val = 13'($urandom_range(6, 1));
                    write_reg(idx[1:0], val);
                end
            end
            len = $urandom_range(60, 1);
            repeat (len) begin
                if ($urandom_range(99) >= 65)
                    px = 8'($urandom_range(255));
                send_pixel(px);
                sent++;
            end
        end
    endtask

    task automatic test_widest_row();
        logic [7:0] px;
        settle();
        write_reg(CFG_ORIGIN_COL, 13'd4095);
        write_reg(CFG_REGION_WIDTH, 13'h1fff);
        px = 8'($urandom_range(255));
        repeat (150) begin
            if ($urandom_range(19) == 0)
                px = 8'($urandom_range(255));
            send_pixel(px);
        end
    endtask

    task automatic test_tallest_region();
        settle();
        write_reg(CFG_ORIGIN_ROW, 13'd4095);
        write_reg(CFG_REGION_WIDTH, 13'd0);
        write_reg(CFG_REGION_HEIGHT, 13'h1fff);
        repeat (150)
            send_pixel(8'($urandom_range(255)));
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_ORIGIN_COL;
        i_cfg_data   = '0;
        pix_ch.valid = 1'b0;
        pix_ch.pixel = '0;
        run_ch.ready = 1'b0;
        error_count  = 0;
        org_col      = '0;
        org_row      = '0;
        reg_width    = RST_REGION_WIDTH;
        reg_height   = RST_REGION_HEIGHT;
        run_value_q  = '0;
        run_start_q  = '0;
        col_q        = '0;
        row_q        = '0;
        pix_gap_pct   = 6;
        run_stall_pct = 50;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_config_mid_row();
        test_single_pixel_rows();
        test_differing_last();
        test_random_frames(530);

        pix_gap_pct   = 50;
        run_stall_pct = 6;
        test_random_frames(530);

        pix_gap_pct   = 0;
        run_stall_pct = 0;
        test_random_frames(530);
        test_widest_row();
        test_tallest_region();

        @(negedge i_clk);
        pix_ch.valid <= 1'b0;
        for (int k = 0; k < 5000 && expected_runs.size() != 0; k++)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (expected_runs.size() != 0) begin
            $display("%0t: %0d expected runs never arrived", $time, expected_runs.size());
            error_count++;
        end
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("%0t: timeout", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
